[hw/rtl/sprc_pkg.sv]
// ----------------------------------------------------------------------------
// sprc_pkg
// Shared sizes, operation codes and the command word passed from the front
// end to the search engine of the sorted point range counter.
// ----------------------------------------------------------------------------
package sprc_pkg;

   localparam int CAPACITY    = 1024;
   localparam int COORD_BITS  = 24;
   localparam int ADDR_BITS   = $clog2(CAPACITY);
   localparam int COUNT_BITS  = ADDR_BITS + 1;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   localparam logic [COUNT_BITS-1:0] COUNT_ONE  = COUNT_BITS'(1);
   localparam logic [COUNT_BITS-1:0] COUNT_FULL = COUNT_BITS'(CAPACITY);

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_INSERT = 2'd1,
      OP_QUERY  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   // one queued command; for a query key_a <= key_b already holds
   typedef struct packed {
      op_type                op;
      logic [COORD_BITS-1:0] key_a;
      logic [COORD_BITS-1:0] key_b;
   } cmd_type;

endpackage

[hw/rtl/sorted_point_range_counter.sv]
// ----------------------------------------------------------------------------
// sorted_point_range_counter
// Sorted table of points on a line with clear, insert and closed-interval
// count; one result word per request word.
// ----------------------------------------------------------------------------
// throughput: one word at a time in the search engine, paced by its single
//   table read port; a four-word queue takes start while it works, rsp never stalls
// reset clears the point count, the queue and the sequencer; table contents
//   are left as they are and are only read below the point count.
module sorted_point_range_counter (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_operation,
   input  logic [sprc_pkg::COORD_BITS-1:0] req_low_bound,
   input  logic [sprc_pkg::COORD_BITS-1:0] req_high_bound,
   output logic                            rsp_valid,
   output logic [sprc_pkg::COUNT_BITS-1:0] rsp_point_total,
   output logic                            rsp_status
);
   import sprc_pkg::*;

   cmd_type front_cmd;
   cmd_type head_cmd;
   logic    queue_empty;
   logic    queue_full;
   logic    pop;

   assign busy = queue_full;

   sprc_front u_front (
      .req_operation  (req_operation),
      .req_low_bound  (req_low_bound),
      .req_high_bound (req_high_bound),
      .cmd            (front_cmd)
   );

   sprc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (start),
      .push_cmd (front_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .empty    (queue_empty),
      .full     (queue_full)
   );

   sprc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_cmd        (head_cmd),
      .queue_empty     (queue_empty),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_point_total (rsp_point_total),
      .rsp_status      (rsp_status)
   );

endmodule

[hw/rtl/sprc_front.sv]
// ----------------------------------------------------------------------------
// sprc_front
// Decodes the incoming request word and orders the query bounds so that the
// search engine always sees the smaller bound first.
// ----------------------------------------------------------------------------
module sprc_front (
   input  logic [1:0]                    req_operation,
   input  logic [sprc_pkg::COORD_BITS-1:0] req_low_bound,
   input  logic [sprc_pkg::COORD_BITS-1:0] req_high_bound,
   output sprc_pkg::cmd_type             cmd
);
   import sprc_pkg::*;

   op_type op;

   assign op = op_type'(req_operation);

   always_comb begin
      cmd.op    = op;
      cmd.key_a = req_low_bound;
      cmd.key_b = req_high_bound;
      unique case (op)
         OP_QUERY: begin
            // reversed bounds are swapped
            if (req_low_bound > req_high_bound) begin
               cmd.key_a = req_high_bound;
               cmd.key_b = req_low_bound;
            end
         end
         OP_INSERT: begin
            cmd.key_b = req_low_bound;
         end
         OP_CLEAR, OP_NONE: begin
            cmd.key_a = '0;
            cmd.key_b = '0;
         end
         default: begin
            cmd.op = OP_NONE;
         end
      endcase
   end

endmodule

[hw/rtl/sprc_queue.sv]
// ----------------------------------------------------------------------------
// sprc_queue
// Short command queue between the front end and the search engine.
// ----------------------------------------------------------------------------
module sprc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sprc_pkg::cmd_type push_cmd,
   input  logic              pop,
   output sprc_pkg::cmd_type head_cmd,
   output logic              empty,
   output logic              full
);
   import sprc_pkg::*;

   cmd_type                slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]     fill_ff, fill_in;
   logic                   do_push, do_pop;

   assign empty    = (fill_ff == '0);
   assign full     = (fill_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_cmd = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + (QPTR_BITS+1)'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - (QPTR_BITS+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   fill_bound_a: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= (QPTR_BITS+1)'(QUEUE_DEPTH))
      else $error("queue fill beyond depth");

   pop_moves_a: assert property (@(posedge clock) disable iff (reset)
      (pop && !empty) |=> (rd_ptr_ff == $past(rd_ptr_ff) + QPTR_BITS'(1)))
      else $error("read pointer did not advance on pop");

   push_full_a: assert property (@(posedge clock) disable iff (reset)
      (push && full && !pop) |=> (fill_ff == $past(fill_ff)))
      else $error("push into full queue changed fill");

endmodule

[hw/rtl/sprc_back.sv]
// ----------------------------------------------------------------------------
// sprc_back
// Search engine: holds the sorted point table and runs clear, insert (search,
// shift up, place; or append) and query (lower and upper bound searches).
// ----------------------------------------------------------------------------
module sprc_back (
   input  logic                          clock,
   input  logic                          reset,
   input  sprc_pkg::cmd_type             head_cmd,
   input  logic                          queue_empty,
   output logic                          pop,
   output logic                          rsp_valid,
   output logic [sprc_pkg::COUNT_BITS-1:0] rsp_point_total,
   output logic                          rsp_status
);
   import sprc_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_SRCH     = 6'b000010,
      S_CMP      = 6'b000100,
      S_SHIFT_RD = 6'b001000,
      S_SHIFT_WR = 6'b010000,
      S_PLACE    = 6'b100000
   } state_type;

   state_type               state_ff, state_in;
   op_type                  op_ff, op_in;
   logic                    upper_ff, upper_in;
   logic                    second_ff, second_in;
   logic [COORD_BITS-1:0]   key_ff, key_in;
   logic [COORD_BITS-1:0]   key2_ff, key2_in;
   logic [COUNT_BITS-1:0]   lo_ff, lo_in;
   logic [COUNT_BITS-1:0]   hi_ff, hi_in;
   logic [COUNT_BITS-1:0]   mid_ff, mid_in;
   logic [COUNT_BITS-1:0]   first_pos_ff, first_pos_in;
   logic [COUNT_BITS-1:0]   pos_ff, pos_in;
   logic [COUNT_BITS-1:0]   idx_ff, idx_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [COUNT_BITS-1:0]   rsp_total_ff, rsp_total_in;
   logic                    rsp_status_ff, rsp_status_in;

   logic [COORD_BITS-1:0]   point_mem_ff [CAPACITY];
   logic [COORD_BITS-1:0]   rd_data_ff;
   logic [ADDR_BITS-1:0]    rd_addr;
   logic [ADDR_BITS-1:0]    wr_addr;
   logic [COORD_BITS-1:0]   wr_data;
   logic                    wr_en;
   logic [COUNT_BITS-1:0]   mid;
   logic [COUNT_BITS-1:0]   idx_dec;
   logic                    go_right;

   assign mid      = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign idx_dec  = idx_ff - COUNT_ONE;
   assign go_right = upper_ff ? (rd_data_ff <= key_ff) : (rd_data_ff < key_ff);
   assign rd_addr  = state_ff == S_SRCH ? mid[ADDR_BITS-1:0] : idx_dec[ADDR_BITS-1:0];

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_total = rsp_total_ff;
   assign rsp_status      = rsp_status_ff;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      upper_in      = upper_ff;
      second_in     = second_ff;
      key_in        = key_ff;
      key2_in       = key2_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      first_pos_in  = first_pos_ff;
      pos_in        = pos_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      rsp_valid_in  = 1'b0;
      rsp_total_in  = '0;
      rsp_status_in = 1'b0;
      pop           = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = idx_ff[ADDR_BITS-1:0];
      wr_data       = rd_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (!queue_empty) begin
               pop       = 1'b1;
               op_in     = head_cmd.op;
               key_in    = head_cmd.key_a;
               key2_in   = head_cmd.key_b;
               lo_in     = '0;
               hi_in     = count_ff;
               second_in = 1'b0;
               unique case (head_cmd.op)
                  OP_CLEAR: begin
                     count_in     = '0;
                     rsp_valid_in = 1'b1;
                  end
                  OP_INSERT: begin
                     if (count_ff == COUNT_FULL) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = 1'b1;
                     end else begin
                        upper_in = 1'b1;
                        state_in = S_SRCH;
                     end
                  end
                  OP_QUERY: begin
                     upper_in = 1'b0;
                     state_in = S_SRCH;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_SRCH: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid;
               state_in = S_CMP;
            end else if (op_ff == OP_INSERT) begin
               pos_in = lo_ff;
               idx_in = count_ff;
               if (count_ff == lo_ff) begin
                  // insert at the end: place directly
                  wr_en        = 1'b1;
                  wr_addr      = lo_ff[ADDR_BITS-1:0];
                  wr_data      = key_ff;
                  count_in     = count_ff + COUNT_ONE;
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  state_in = S_SHIFT_RD;
               end
            end else if (!second_ff) begin
               // lower bound found, now the upper bound of the larger key
               first_pos_in = lo_ff;
               second_in    = 1'b1;
               upper_in     = 1'b1;
               key_in       = key2_ff;
               lo_in        = '0;
               hi_in        = count_ff;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_total_in = lo_ff - first_pos_ff;
               state_in     = S_IDLE;
            end
         end
         S_CMP: begin
            if (go_right) begin
               lo_in = mid_ff + COUNT_ONE;
            end else begin
               hi_in = mid_ff;
            end
            state_in = S_SRCH;
         end
         S_SHIFT_RD: begin
            state_in = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[ADDR_BITS-1:0];
            wr_data = rd_data_ff;
            idx_in  = idx_dec;
            if (idx_dec == pos_ff) begin
               state_in = S_PLACE;
            end else begin
               state_in = S_SHIFT_RD;
            end
         end
         S_PLACE: begin
            // placing the new point after the shift
            wr_en        = 1'b1;
            wr_addr      = pos_ff[ADDR_BITS-1:0];
            wr_data      = key_ff;
            count_in     = count_ff + COUNT_ONE;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      upper_ff      <= upper_in;
      second_ff     <= second_in;
      key_ff        <= key_in;
      key2_ff       <= key2_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      first_pos_ff  <= first_pos_in;
      pos_ff        <= pos_in;
      idx_ff        <= idx_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         point_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= point_mem_ff[rd_addr];
   end

   count_bound_a: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_FULL)
      else $error("point count beyond capacity");

   cmp_after_read_a: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CMP |-> $past(state_ff) == S_SRCH)
      else $error("compare without a table read");

   search_window_a: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SRCH || state_ff == S_CMP) |-> (lo_ff <= hi_ff && hi_ff <= count_ff))
      else $error("search window out of order");

   shift_range_a: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT_RD || state_ff == S_SHIFT_WR) |-> (idx_ff > pos_ff))
      else $error("shift index below insert position");

   dropped_zero_a: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |-> (rsp_total_ff == '0))
      else $error("dropped insert with nonzero total");

endmodule

[verif/tb_sorted_point_range_counter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_point_range_counter
// Drives clear, insert, query and unused-code words into the point table,
// keeps its own sorted copy of the table to work out each expected count and
// status, and checks every result word in order against those expectations.
// ----------------------------------------------------------------------------
module tb_sorted_point_range_counter;
   import sprc_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int TARGET_WORDS   = 1600;

   typedef struct packed {
      logic [COUNT_BITS-1:0] total;
      logic                  status;
   } count_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [1:0]            req_operation = 2'd0;
   logic [COORD_BITS-1:0] req_low_bound = '0;
   logic [COORD_BITS-1:0] req_high_bound = '0;
   logic                  rsp_valid;
   logic [COUNT_BITS-1:0] rsp_point_total;
   logic                  rsp_status;

   cmd_type               request_words[$];
   count_result_type      expected_counts[$];
   logic [COORD_BITS-1:0] gen_points[$];

   // shadow of the point table
   logic [COORD_BITS-1:0] shadow_points[CAPACITY];
   int                    shadow_count = 0;

   int   total_words = 0;
   int   accepted_words = 0;
   int   mismatch_count = 0;
   int   stall_cycles = 0;
   logic word_taken;

   sorted_point_range_counter dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_low_bound   (req_low_bound),
      .req_high_bound  (req_high_bound),
      .rsp_valid       (rsp_valid),
      .rsp_point_total (rsp_point_total),
      .rsp_status      (rsp_status)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- shadow table

   function automatic int count_below(input logic [COORD_BITS-1:0] key);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = shadow_count;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (shadow_points[mid] < key) lo = mid + 1;
         else hi = mid;
      end
      return lo;
   endfunction

   function automatic int count_at_or_below(input logic [COORD_BITS-1:0] key);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = shadow_count;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (shadow_points[mid] <= key) lo = mid + 1;
         else hi = mid;
      end
      return lo;
   endfunction

   function automatic count_result_type apply_to_table(input op_type op,
                                                        input logic [COORD_BITS-1:0] a,
                                                        input logic [COORD_BITS-1:0] b);
      count_result_type      res;
      logic [COORD_BITS-1:0] lo_key;
      logic [COORD_BITS-1:0] hi_key;
      int                    pos;
      res = '0;
      case (op)
         OP_CLEAR: begin
            shadow_count = 0;
         end
         OP_INSERT: begin
            if (shadow_count >= CAPACITY) begin
               res.status = 1'b1;
            end else begin
               // equal points stay ahead of the new one
               pos = count_at_or_below(a);
               for (int i = shadow_count; i > pos; i--)
                  shadow_points[i] = shadow_points[i-1];
               shadow_points[pos] = a;
               shadow_count++;
            end
         end
         OP_QUERY: begin
            lo_key = (a > b) ? b : a;
            hi_key = (a > b) ? a : b;
            res.total = COUNT_BITS'(count_at_or_below(hi_key) - count_below(lo_key));
         end
         default: ;
      endcase
      return res;
   endfunction

   // ---------------------------------------------------------------- stimulus

   task automatic push_word(input op_type op, input logic [COORD_BITS-1:0] a,
                            input logic [COORD_BITS-1:0] b);
      cmd_type w;
      w.op    = op;
      w.key_a = a;
      w.key_b = b;
      request_words.push_back(w);
      if (op == OP_CLEAR) gen_points.delete();
      else if (op == OP_INSERT && gen_points.size() < CAPACITY) gen_points.push_back(a);
   endtask

   function automatic logic [COORD_BITS-1:0] pick_key();
      logic [COORD_BITS-1:0] k;
      k = COORD_BITS'($urandom);
      case ($urandom_range(5))
         0: k = '0;
         1: k = '1;
         2, 3: begin
            if (gen_points.size() != 0) k = gen_points[$urandom_range(gen_points.size() - 1)];
         end
         4: begin
            // just beside a stored point
            if (gen_points.size() != 0) begin
               k = gen_points[$urandom_range(gen_points.size() - 1)];
               k = $urandom_range(1) ? k + 1'b1 : k - 1'b1;
            end
         end
         default: ;
      endcase
      return k;
   endfunction

   task automatic push_query();
      logic [COORD_BITS-1:0] a;
      logic [COORD_BITS-1:0] b;
      a = pick_key();
      b = ($urandom_range(7) == 0) ? a : pick_key();
      push_word(OP_QUERY, a, b);
   endtask

   task automatic random_session();
      int                    n;
      int                    roll;
      logic [COORD_BITS-1:0] window;
      logic [COORD_BITS-1:0] v;
      n = $urandom_range(60, 4);
      window = COORD_BITS'($urandom);
      if ($urandom_range(3) != 0) push_word(OP_CLEAR, COORD_BITS'($urandom), COORD_BITS'($urandom));
      repeat (n) begin
         roll = $urandom_range(99);
         if (roll < 45 && gen_points.size() < 200) begin
            case ($urandom_range(2))
               0: v = COORD_BITS'($urandom);
               1: v = window + COORD_BITS'($urandom_range(15));
               default: v = pick_key();
            endcase
            push_word(OP_INSERT, v, COORD_BITS'($urandom));
         end else if (roll < 91) begin
            push_query();
         end else if (roll < 96) begin
            push_word(OP_NONE, COORD_BITS'($urandom), COORD_BITS'($urandom));
         end else begin
            push_word(OP_CLEAR, COORD_BITS'($urandom), COORD_BITS'($urandom));
         end
      end
   endtask

   // mostly appends so the fill stays cheap, a few inserts land mid-table
   task automatic fill_session();
      logic [COORD_BITS-1:0] next_key;
      int                    roll;
      push_word(OP_CLEAR, '0, '0);
      next_key = COORD_BITS'($urandom_range(4000));
      while (gen_points.size() < CAPACITY) begin
         roll = $urandom_range(255);
         if (roll < 2) begin
            push_word(OP_INSERT, COORD_BITS'($urandom), COORD_BITS'($urandom));
         end else if (roll < 14) begin
            push_query();
         end else begin
            if ($urandom_range(3) != 0) next_key = next_key + COORD_BITS'($urandom_range(8000));
            push_word(OP_INSERT, next_key, COORD_BITS'($urandom));
         end
      end
      // table full: inserts are dropped
      repeat (3) push_word(OP_INSERT, COORD_BITS'($urandom), COORD_BITS'($urandom));
      push_word(OP_QUERY, '0, '1);
      push_word(OP_QUERY, '1, '0);
      repeat (6) push_query();
      push_word(OP_INSERT, '1, '0);
      push_word(OP_INSERT, '0, '1);
      push_word(OP_NONE, '1, '1);
      push_query();
      push_word(OP_CLEAR, '1, '1);
      push_word(OP_QUERY, '0, '1);
   endtask

   task automatic directed_words();
      push_word(OP_QUERY, '0, '1);                 // empty table
      push_word(OP_NONE, '1, '0);
      push_word(OP_INSERT, '0, '1);
      push_word(OP_INSERT, '1, '0);
      push_word(OP_INSERT, COORD_BITS'(1000), '1);
      push_word(OP_INSERT, COORD_BITS'(1000), '0);
      push_word(OP_INSERT, COORD_BITS'(1000), COORD_BITS'($urandom));
      push_word(OP_INSERT, COORD_BITS'(999), '0);
      push_word(OP_INSERT, COORD_BITS'(1001), '0);
      push_word(OP_QUERY, '0, '0);
      push_word(OP_QUERY, '1, '1);
      push_word(OP_QUERY, COORD_BITS'(1000), COORD_BITS'(1000));
      push_word(OP_QUERY, COORD_BITS'(1001), COORD_BITS'(999)); // reversed bounds
      push_word(OP_QUERY, '0, '1);
      push_word(OP_QUERY, '1, '0);
      push_word(OP_QUERY, COORD_BITS'(1), COORD_BITS'(24'hFFFFFE));
      push_word(OP_QUERY, COORD_BITS'(1002), COORD_BITS'(1003));
      push_word(OP_NONE, '0, '0);
      push_word(OP_CLEAR, '1, '1);
      push_word(OP_QUERY, '0, '1);
      push_word(OP_QUERY, '1, '1);
   endtask

   // ---------------------------------------------------------------- driver

   function automatic int sender_idle_pct();
      if (accepted_words < total_words / 3) return 22;
      if (accepted_words < 2 * total_words / 3) return 88;
      return 0;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         start          <= 1'b0;
         req_operation  <= 2'd0;
         req_low_bound  <= '0;
         req_high_bound <= '0;
      end else begin
         word_taken = start && !busy;
         if (word_taken) begin
            expected_counts.push_back(apply_to_table(op_type'(req_operation),
                                                     req_low_bound, req_high_bound));
            void'(request_words.pop_front());
            accepted_words++;
         end
         if (start && !word_taken) begin
            // hold the word until taken
         end else if (request_words.size() != 0 &&
                      $urandom_range(99) >= sender_idle_pct()) begin
            start          <= 1'b1;
            req_operation  <= request_words[0].op;
            req_low_bound  <= request_words[0].key_a;
            req_high_bound <= request_words[0].key_b;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      count_result_type want;
      if (!reset && rsp_valid) begin
         if (expected_counts.size() == 0) begin
            if (mismatch_count < 10)
               $display("%0t: unexpected result word total=%0d status=%0b",
                        $realtime, rsp_point_total, rsp_status);
            mismatch_count++;
         end else begin
            want = expected_counts.pop_front();
            if (rsp_point_total !== want.total || rsp_status !== want.status) begin
               if (mismatch_count < 10)
                  $display("%0t: mismatch total exp=%0d got=%0d status exp=%0b got=%0b",
                           $realtime, want.total, rsp_point_total, want.status, rsp_status);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_valid) stall_cycles <= 0;
         else stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      directed_words();
      while (request_words.size() < 350) random_session();
      fill_session();
      while (request_words.size() < TARGET_WORDS) random_session();
      total_words = request_words.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (request_words.size() != 0 || expected_counts.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (mismatch_count == 0 && expected_counts.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

[files.f]
hw/rtl/sprc_pkg.sv
hw/rtl/sprc_front.sv
hw/rtl/sprc_queue.sv
hw/rtl/sprc_back.sv
hw/rtl/sorted_point_range_counter.sv
verif/tb_sorted_point_range_counter.sv
